>>> rtl/llas_pkg.sv
`timescale 1ns / 1ps

package llas_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int AddrW      = RowW + 1;
  localparam int Depth      = 2 * MaxHeight;
  localparam int SizeW      = 7;
  localparam int MaskW      = 9;
  localparam int CountW     = 4;
  localparam int SweepSteps = MaxHeight + 2;
  localparam int StepW      = $clog2(SweepSteps);

  localparam logic [SizeW-1:0] WidthReset   = 7'd64;
  localparam logic [SizeW-1:0] HeightReset  = 7'd64;
  localparam logic [MaskW-1:0] SurviveReset = 9'd12;
  localparam logic [MaskW-1:0] BornReset    = 9'd8;

  typedef enum logic [1:0] {
    ReqWrite = 2'd0,
    ReqRead  = 2'd1,
    ReqStep  = 2'd2,
    ReqNone  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CfgWidth   = 2'd0,
    CfgHeight  = 2'd1,
    CfgSurvive = 2'd2,
    CfgBorn    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic latch;
    logic rd_cell;
    logic wr_cell;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic coord_err;
    logic sweep_last;
  } sts_t;

endpackage

>>> rtl/life_like_automaton_step.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_type, col_index, row_index, alive_in
// rsp       out        rsp_valid/rsp_ready    cell_value, step_done, coord_error
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A cell write or read passes the decode, cell and response states; an error or unused
// request goes from decode straight to response; a generation sweeps one row per cycle
// through the single read port of the row memory (two planes of MaxHeight rows each).
// One request is in work at a time; a new one is taken while a response waits.
// Reset clears the grid at once through per-row valid bits; no clearing pass.
// A stalled response holds the controller in its response state.

module life_like_automaton_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 req_type,
  input  logic [llas_pkg::ColW-1:0]  col_index,
  input  logic [llas_pkg::RowW-1:0]  row_index,
  input  logic                       alive_in,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       cell_value,
  output logic                       step_done,
  output logic                       coord_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [llas_pkg::MaskW-1:0] cfg_data
);

  llas_pkg::cmd_t cmd;
  llas_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  llas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  llas_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_sel     (llas_pkg::cfg_reg_t'(cfg_index)),
    .cfg_wdata   (cfg_data),
    .req_type    (req_type),
    .col_index   (col_index),
    .row_index   (row_index),
    .alive_in    (alive_in),
    .cmd         (cmd),
    .sts         (sts),
    .cell_value  (cell_value),
    .step_done   (step_done),
    .coord_error (coord_error)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_step_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && step_done |-> !coord_error && !cell_value)
    else $error("generation response carries cell or error flags");

  a_error_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && coord_error |-> !cell_value && !step_done)
    else $error("error response carries data");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");
`endif

endmodule

>>> rtl/llas_ctrl.sv
`timescale 1ns / 1ps

module llas_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  llas_pkg::sts_t  sts,
  output llas_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StCell,
    StSweep,
    StResp
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == StIdle);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      StIdle: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = StDecode;
        end
      end
      StDecode: begin
        if ((sts.req == llas_pkg::ReqWrite || sts.req == llas_pkg::ReqRead)
            && !sts.coord_err) begin
          cmd.rd_cell = 1'b1;
          state_next  = StCell;
        end else if (sts.req == llas_pkg::ReqStep) begin
          state_next = StSweep;
        end else begin
          state_next = StResp;
        end
      end
      StCell: begin
        cmd.wr_cell = (sts.req == llas_pkg::ReqWrite);
        state_next  = StResp;
      end
      StSweep: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = StResp;
        end
      end
      StResp: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/llas_datapath.sv
`timescale 1ns / 1ps

module llas_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  llas_pkg::cfg_reg_t          cfg_sel,
  input  logic [llas_pkg::MaskW-1:0]  cfg_wdata,
  input  logic [1:0]                  req_type,
  input  logic [llas_pkg::ColW-1:0]   col_index,
  input  logic [llas_pkg::RowW-1:0]   row_index,
  input  logic                        alive_in,
  input  llas_pkg::cmd_t              cmd,
  output llas_pkg::sts_t              sts,
  output logic                        cell_value,
  output logic                        step_done,
  output logic                        coord_error
);

  logic [llas_pkg::SizeW-1:0] grid_width;
  logic [llas_pkg::SizeW-1:0] grid_height;
  logic [llas_pkg::MaskW-1:0] survive_mask;
  logic [llas_pkg::MaskW-1:0] born_mask;
  logic                       active_plane;

  llas_pkg::req_t            lat_req;
  logic [llas_pkg::ColW-1:0] lat_col;
  logic [llas_pkg::RowW-1:0] lat_row;
  logic                      lat_alive;

  logic [llas_pkg::SizeW-1:0] w_eff;
  logic [llas_pkg::SizeW-1:0] h_eff;
  logic                       coord_err;

  logic [llas_pkg::MaxWidth-1:0] mem [llas_pkg::Depth];
  logic [llas_pkg::Depth-1:0]    row_valid;
  logic [llas_pkg::MaxWidth-1:0] rd_data;
  logic [llas_pkg::MaxWidth-1:0] above;
  logic [llas_pkg::MaxWidth-1:0] mid;
  logic [llas_pkg::MaxWidth-1:0] next_row;
  logic [llas_pkg::MaxWidth-1:0] cell_row;

  logic [llas_pkg::StepW-1:0] step;
  logic [llas_pkg::StepW-1:0] step_less2;
  logic [llas_pkg::RowW-1:0]  wr_row_idx;
  logic                       sweep_rd;
  logic                       sweep_wr;
  logic                       sweep_last;

  logic                       rd_en;
  logic [llas_pkg::AddrW-1:0] rd_addr;
  logic                       wr_en;
  logic [llas_pkg::AddrW-1:0] wr_addr;
  logic [llas_pkg::MaxWidth-1:0] wr_data;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = llas_pkg::SizeW'(1);
    end else if (grid_width > llas_pkg::SizeW'(llas_pkg::MaxWidth)) begin
      w_eff = llas_pkg::SizeW'(llas_pkg::MaxWidth);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = llas_pkg::SizeW'(1);
    end else if (grid_height > llas_pkg::SizeW'(llas_pkg::MaxHeight)) begin
      h_eff = llas_pkg::SizeW'(llas_pkg::MaxHeight);
    end else begin
      h_eff = grid_height;
    end
  end

  assign coord_err = (llas_pkg::SizeW'(lat_col) >= w_eff) ||
                     (llas_pkg::SizeW'(lat_row) >= h_eff);

  assign step_less2 = step - llas_pkg::StepW'(2);
  assign wr_row_idx = step_less2[llas_pkg::RowW-1:0];
  assign sweep_rd   = cmd.sweep && (step < llas_pkg::StepW'(llas_pkg::MaxHeight));
  assign sweep_wr   = cmd.sweep && (step >= llas_pkg::StepW'(2));
  assign sweep_last = (step == llas_pkg::StepW'(llas_pkg::SweepSteps - 1));

  assign sts.req        = lat_req;
  assign sts.coord_err  = coord_err;
  assign sts.sweep_last = sweep_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= llas_pkg::WidthReset;
      grid_height  <= llas_pkg::HeightReset;
      survive_mask <= llas_pkg::SurviveReset;
      born_mask    <= llas_pkg::BornReset;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        llas_pkg::CfgWidth:   grid_width   <= cfg_wdata[llas_pkg::SizeW-1:0];
        llas_pkg::CfgHeight:  grid_height  <= cfg_wdata[llas_pkg::SizeW-1:0];
        llas_pkg::CfgSurvive: survive_mask <= cfg_wdata;
        llas_pkg::CfgBorn:    born_mask    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_req   <= llas_pkg::req_t'(req_type);
      lat_col   <= col_index;
      lat_row   <= row_index;
      lat_alive <= alive_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      active_plane <= 1'b0;
    end else if (cmd.latch) begin
      step <= '0;
    end else if (cmd.sweep) begin
      step <= step + llas_pkg::StepW'(1);
      if (sweep_last) begin
        active_plane <= ~active_plane;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep && step != '0) begin
      above <= mid;
      mid   <= rd_data;
    end
  end

  always_comb begin
    logic [llas_pkg::MaxWidth+1:0] ap;
    logic [llas_pkg::MaxWidth+1:0] mp;
    logic [llas_pkg::MaxWidth+1:0] bp;
    logic [llas_pkg::CountW-1:0]   nb;
    logic                          row_use;
    logic                          row_edge;
    logic                          col_use;
    logic                          col_edge;
    ap       = {1'b0, above, 1'b0};
    mp       = {1'b0, mid, 1'b0};
    bp       = {1'b0, rd_data, 1'b0};
    row_use  = llas_pkg::SizeW'(wr_row_idx) < h_eff;
    row_edge = (wr_row_idx == '0) ||
               (llas_pkg::SizeW'(wr_row_idx) == h_eff - llas_pkg::SizeW'(1));
    for (int c = 0; c < llas_pkg::MaxWidth; c++) begin
      nb = llas_pkg::CountW'(ap[c]) + llas_pkg::CountW'(ap[c+1]) +
           llas_pkg::CountW'(ap[c+2]) + llas_pkg::CountW'(mp[c]) +
           llas_pkg::CountW'(mp[c+2]) + llas_pkg::CountW'(bp[c]) +
           llas_pkg::CountW'(bp[c+1]) + llas_pkg::CountW'(bp[c+2]);
      col_use  = llas_pkg::SizeW'(c) < w_eff;
      col_edge = (c == 0) || (llas_pkg::SizeW'(c) == w_eff - llas_pkg::SizeW'(1));
      if (!(row_use && col_use)) begin
        next_row[c] = mid[c];
      end else if (row_edge || col_edge) begin
        next_row[c] = 1'b1;
      end else if (mid[c]) begin
        next_row[c] = survive_mask[nb];
      end else begin
        next_row[c] = born_mask[nb];
      end
    end
  end

  always_comb begin
    cell_row          = rd_data;
    cell_row[lat_col] = lat_alive;
  end

  always_comb begin
    rd_en   = cmd.rd_cell || sweep_rd;
    rd_addr = cmd.sweep ? {active_plane, step[llas_pkg::RowW-1:0]}
                        : {active_plane, lat_row};
    wr_en   = cmd.wr_cell || sweep_wr;
    wr_addr = cmd.sweep ? {~active_plane, wr_row_idx} : {active_plane, lat_row};
    wr_data = cmd.sweep ? next_row : cell_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_value  <= (lat_req == llas_pkg::ReqRead) && !coord_err && rd_data[lat_col];
      step_done   <= (lat_req == llas_pkg::ReqStep);
      coord_error <= (lat_req == llas_pkg::ReqWrite || lat_req == llas_pkg::ReqRead)
                     && coord_err;
    end
  end

endmodule
